@@ hw/rtl/hcbp_pkg.sv @@
`default_nettype none

package hcbp_pkg;

  // Default sizes of the code table.
  localparam int SYMBOL_COUNT_DEF = 256;
  localparam int MAX_CODE_LEN_DEF = 32;

  // Fixed widths of the stream fields.
  localparam int SYMBOL_W   = 8;
  localparam int CODE_IN_W  = 32;
  localparam int LEN_IN_W   = 6;
  localparam int BYTE_W     = 8;
  localparam int IN_DATA_W  = 48;
  localparam int REQ_W      = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD   = 2'd0,
    REQ_ENCODE = 2'd1,
    REQ_FLUSH  = 2'd2,
    REQ_NONE   = 2'd3
  } req_type_t;

endpackage

`default_nettype wire

@@ hw/rtl/huffman_code_bit_packer.sv @@
// Load request: the table entry is written at acceptance. Encode request: a lookup
// state, then one packing step per cycle unless a full byte waits on the output
// register; each step moves up to eight code bits, so a nonzero code takes 1 to 5
// steps, and no new request is taken until it is done. The byte packer is the shared
// unit. Flush request: a flush state when bits are pending. rst is synchronous,
// active high; it empties the bit accumulator and the output stage, not the table.
`default_nettype none

module huffman_code_bit_packer #(
  parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Request stream.
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // s_tdata from bit 0: symbol[7:0], code_bits[39:8], code_length[45:40], zero pad.
  input  wire logic [hcbp_pkg::IN_DATA_W-1:0]  s_tdata,
  // s_tuser: req_type[1:0].
  input  wire logic [hcbp_pkg::REQ_W-1:0]      s_tuser,
  // Result stream.
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // m_tdata: out_byte[7:0], first code bit in bit 7.
  output logic      [hcbp_pkg::BYTE_W-1:0]     m_tdata,
  // m_tlast: last_of_run, set on the final byte that a request produces.
  output logic                                 m_tlast
);
  import hcbp_pkg::*;

  localparam int AW = $clog2(SYMBOL_COUNT);
  localparam int LW = $clog2(MAX_CODE_LEN + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LOOK  = 4'b0010,
    ST_PACK  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  // Unpack the request fields.
  req_type_t               req;
  logic [SYMBOL_W-1:0]     sym;
  logic [CODE_IN_W-1:0]    code_in;
  logic [LEN_IN_W-1:0]     len_in;

  assign req     = req_type_t'(s_tuser);
  assign sym     = s_tdata[SYMBOL_W-1:0];
  assign code_in = s_tdata[SYMBOL_W+CODE_IN_W-1:SYMBOL_W];
  assign len_in  = s_tdata[SYMBOL_W+CODE_IN_W+LEN_IN_W-1:SYMBOL_W+CODE_IN_W];

  state_t                  state, state_next;
  logic [MAX_CODE_LEN-1:0] code_word, code_word_next;  // remaining bits, MSB first
  logic [LW-1:0]           rem, rem_next;              // bits left in code_word
  logic [BYTE_W-1:0]       pend_bits, pend_bits_next;  // accumulator, right aligned
  logic [2:0]              pend_count, pend_count_next;
  logic                    m_tvalid_next;
  logic [BYTE_W-1:0]       m_tdata_next;
  logic                    m_tlast_next;

  logic                    s_accept;
  logic                    in_range;
  logic                    out_free;

  logic                    wr_en;
  logic [MAX_CODE_LEN-1:0] wr_code;
  logic [LW-1:0]           wr_len;
  logic                    rd_en;
  logic [MAX_CODE_LEN-1:0] rd_code;
  logic [LW-1:0]           rd_len;

  // Packing step signals.
  logic [3:0]              room;
  logic [LW-1:0]           take;
  logic [3:0]              take4;
  logic [BYTE_W-1:0]       window;
  logic [BYTE_W-1:0]       new_bits;
  logic [2*BYTE_W-1:0]     pend_shift;
  logic [2*BYTE_W-1:0]     flush_shift;
  logic                    step_full;
  logic [LW-1:0]           rem_after;
  logic [LW-1:0]           align_amt;

  assign s_tready = (state == ST_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign in_range = ({1'b0, sym} < 9'(SYMBOL_COUNT));
  assign out_free = !m_tvalid || m_tready;

  // A load clamps an overlong length; the stored code keeps its low bits only.
  assign wr_en   = s_accept && (req == REQ_LOAD) && in_range;
  assign wr_code = code_in[MAX_CODE_LEN-1:0];
  assign wr_len  = (len_in > LEN_IN_W'(MAX_CODE_LEN)) ? LW'(MAX_CODE_LEN) : len_in[LW-1:0];
  assign rd_en   = s_accept && (req == REQ_ENCODE) && in_range;

  hcbp_table #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .AW           (AW),
    .LW           (LW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (sym[AW-1:0]),
    .wr_code (wr_code),
    .wr_len  (wr_len),
    .rd_en   (rd_en),
    .rd_addr (sym[AW-1:0]),
    .rd_code (rd_code),
    .rd_len  (rd_len)
  );

  // One packing step: move as many leading code bits as fit in the accumulator.
  // The code is kept left aligned, so those bits always sit at the top of code_word.
  assign room        = 4'd8 - {1'b0, pend_count};
  assign take        = (rem < LW'(room)) ? rem : LW'(room);
  assign take4       = take[3:0];
  assign window      = code_word[MAX_CODE_LEN-1 -: BYTE_W];
  assign new_bits    = window >> (4'd8 - take4);
  assign pend_shift  = {{BYTE_W{1'b0}}, pend_bits} << take4;
  assign step_full   = ({1'b0, pend_count} + take4) == 4'd8;
  assign rem_after   = rem - take;
  assign flush_shift = {{BYTE_W{1'b0}}, pend_bits} << room;
  assign align_amt   = LW'(MAX_CODE_LEN) - rd_len;

  always_comb begin
    state_next      = state;
    code_word_next  = code_word;
    rem_next        = rem;
    pend_bits_next  = pend_bits;
    pend_count_next = pend_count;
    m_tvalid_next   = m_tvalid && !m_tready;
    m_tdata_next    = m_tdata;
    m_tlast_next    = m_tlast;

    unique case (state)
      ST_IDLE: begin
        if (s_accept) begin
          if (rd_en) begin
            state_next = ST_LOOK;
          end else if ((req == REQ_FLUSH) && (pend_count != 3'd0)) begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_LOOK: begin
        // A zero length code produces nothing.
        code_word_next = rd_code << align_amt;
        rem_next       = rd_len;
        state_next     = (rd_len == '0) ? ST_IDLE : ST_PACK;
      end
      ST_PACK: begin
        // A step that completes a byte waits for the output register.
        if (!step_full || out_free) begin
          code_word_next = code_word << take4;
          rem_next       = rem_after;
          if (step_full) begin
            pend_bits_next  = '0;
            pend_count_next = 3'd0;
            m_tvalid_next   = 1'b1;
            m_tdata_next    = pend_shift[BYTE_W-1:0] | new_bits;
            m_tlast_next    = (rem_after < LW'(8));
          end else begin
            pend_bits_next  = pend_shift[BYTE_W-1:0] | new_bits;
            pend_count_next = pend_count + take4[2:0];
          end
          if (rem_after == '0) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        // Pending bits go out left aligned, padded with zeros below.
        if (out_free) begin
          m_tvalid_next   = 1'b1;
          m_tdata_next    = flush_shift[BYTE_W-1:0];
          m_tlast_next    = 1'b1;
          pend_bits_next  = '0;
          pend_count_next = 3'd0;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pend_bits  <= '0;
      pend_count <= 3'd0;
      m_tvalid   <= 1'b0;
    end else begin
      state      <= state_next;
      pend_bits  <= pend_bits_next;
      pend_count <= pend_count_next;
      m_tvalid   <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    code_word <= code_word_next;
    rem       <= rem_next;
    m_tdata   <= m_tdata_next;
    m_tlast   <= m_tlast_next;
  end

  // The packer only runs with bits left to place.
  a_pack_has_bits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PACK) |-> (rem != '0))
    else $error("packing step with no code bits left");

  // A byte that is not the last of its request means the packer is still busy.
  a_more_bytes_follow: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (state == ST_PACK))
    else $error("non-final byte shown while packer is idle");

  // A flush with pending bits must move to the flush step.
  a_flush_taken: assert property (@(posedge clk) disable iff (rst)
    (s_accept && (req == REQ_FLUSH) && (pend_count != 3'd0)) |=> (state == ST_FLUSH))
    else $error("flush request with pending bits was dropped");

endmodule

`default_nettype wire

@@ hw/rtl/hcbp_table.sv @@
`default_nettype none

module hcbp_table #(
  parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
  parameter int AW           = $clog2(SYMBOL_COUNT),
  parameter int LW           = $clog2(MAX_CODE_LEN + 1)
) (
  input  wire logic                    clk,
  input  wire logic                    wr_en,
  input  wire logic [AW-1:0]           wr_addr,
  input  wire logic [MAX_CODE_LEN-1:0] wr_code,
  input  wire logic [LW-1:0]           wr_len,
  input  wire logic                    rd_en,
  input  wire logic [AW-1:0]           rd_addr,
  output logic      [MAX_CODE_LEN-1:0] rd_code,
  output logic      [LW-1:0]           rd_len
);
  import hcbp_pkg::*;

  // Code bits and lengths share one address; entries are undefined until loaded.
  logic [MAX_CODE_LEN-1:0] code_mem [SYMBOL_COUNT];
  logic [LW-1:0]           len_mem  [SYMBOL_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      code_mem[wr_addr] <= wr_code;
      len_mem[wr_addr]  <= wr_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_code <= code_mem[rd_addr];
      rd_len  <= len_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ bench/tb_huffman_code_bit_packer.sv @@
`default_nettype none

module tb_huffman_code_bit_packer;
  import hcbp_pkg::*;

  localparam int PERIOD         = 10;
  localparam int RESET_CYCLES   = 8;
  // Quiet spell allowed before the run is declared hung. The slowest legal
  // spell is a long sender gap, a five-step encode and a long receiver stall
  // back to back.
  localparam int WATCHDOG_LIMIT = 2000;
  // Cycles to keep watching the result stream once nothing is expected.
  localparam int TAIL_CYCLES    = 16;

  // One request as it travels on the input stream.
  typedef struct packed {
    req_type_t   kind;
    logic [7:0]  sym;
    logic [31:0] code;
    logic [5:0]  len;
  } huff_req_t;

  // One packed byte together with its end-of-request mark.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } packed_byte_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [REQ_W-1:0]     s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [BYTE_W-1:0]    m_tdata;
  logic                 m_tlast;

  huffman_code_bit_packer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Requests waiting to be driven, filled ahead of time by the stimulus block.
  huff_req_t    pending_reqs[$];
  // Bytes the packer owes us, oldest first, filled as requests are accepted.
  packed_byte_t expected_bytes[$];

  // Our own copy of the code table and the bit accumulator.
  logic [31:0]  shadow_code [SYMBOL_COUNT_DEF];
  int           shadow_len  [SYMBOL_COUNT_DEF];
  logic [7:0]   acc_bits = '0;
  int           acc_count = 0;

  // Which table entries the stimulus has loaded so far. Encoding an entry
  // that was never loaded is not allowed, so encodes only pick from this list.
  bit           sym_loaded [SYMBOL_COUNT_DEF];
  logic [7:0]   loaded_syms[$];

  int           mismatches = 0;
  int           quiet_cycles = 0;
  // While set, neither side inserts idle cycles.
  bit           calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #(PERIOD / 2) clk = ~clk;
  end

  // Idle stretch length: mostly short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    else if (r < 92) return $urandom_range(4, 12);
    else return $urandom_range(30, 80);
  endfunction

  // Advance the predicted packer state by one accepted request and queue
  // whatever bytes it must produce.
  task automatic pack_request(input huff_req_t r);
    int          clen;
    int          nbytes;
    int          made;
    int          idx;
    logic [7:0]  padded;
    logic [31:0] code;
    made = 0;
    case (r.kind)
      REQ_LOAD: begin
        // Lengths beyond the table's limit saturate.
        shadow_code[r.sym] = r.code;
        shadow_len[r.sym]  = (r.len > MAX_CODE_LEN_DEF) ? MAX_CODE_LEN_DEF : int'(r.len);
      end
      REQ_ENCODE: begin
        clen   = shadow_len[r.sym];
        code   = shadow_code[r.sym];
        nbytes = (acc_count + clen) / 8;
        // Bits go in most significant first; only the low clen code bits count.
        for (idx = clen; idx > 0; idx--) begin
          acc_bits  = {acc_bits[6:0], code[idx-1]};
          acc_count = acc_count + 1;
          if (acc_count == 8) begin
            made = made + 1;
            expected_bytes.push_back({acc_bits, made == nbytes});
            acc_bits  = '0;
            acc_count = 0;
          end
        end
      end
      REQ_FLUSH: begin
        // An empty accumulator flushes to nothing.
        if (acc_count != 0) begin
          padded = acc_bits << (8 - acc_count);
          expected_bytes.push_back({padded, 1'b1});
          acc_bits  = '0;
          acc_count = 0;
        end
      end
      default: begin
        // The unused request type leaves everything alone.
      end
    endcase
  endtask

  function automatic void queue_req(input req_type_t kind, input logic [7:0] sym,
                                    input logic [31:0] code, input logic [5:0] len);
    huff_req_t r;
    r.kind = kind;
    r.sym  = sym;
    r.code = code;
    r.len  = len;
    pending_reqs.push_back(r);
    if (kind == REQ_LOAD && !sym_loaded[sym]) begin
      sym_loaded[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
  endfunction

  // Code lengths: mostly short codes, some long ones, a few empty ones and a
  // few above the limit so that all six length bits get exercised.
  function automatic logic [5:0] random_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 6'd0;
    else if (r < 70) return 6'($urandom_range(1, 12));
    else if (r < 88) return 6'($urandom_range(13, 32));
    else return 6'($urandom_range(33, 63));
  endfunction

  // Random mix of loads, encodes and flushes. Unused-type requests are thrown
  // in as noise and do not count toward the total.
  task automatic queue_random(input int count);
    int made;
    int pick;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        queue_req(REQ_LOAD, 8'($urandom_range(0, 255)), $urandom, random_length());
        made = made + 1;
      end else if (pick < 84) begin
        // Unused fields of an encode carry junk on purpose.
        queue_req(REQ_ENCODE, loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
                  $urandom, 6'($urandom_range(0, 63)));
        made = made + 1;
      end else if (pick < 96) begin
        queue_req(REQ_FLUSH, 8'($urandom_range(0, 255)), $urandom,
                  6'($urandom_range(0, 63)));
        made = made + 1;
      end else begin
        queue_req(REQ_NONE, 8'($urandom_range(0, 255)), $urandom,
                  6'($urandom_range(0, 63)));
      end
    end
  endtask

  // Hold the stimulus until every queued request went out and every byte it
  // caused has come back.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_reqs.size() != 0 || s_tvalid || expected_bytes.size() != 0)
      @(negedge clk);
  endtask

  // Request driver. A new request is put up when the slot is free and the
  // current gap has run out; each accepted request updates the prediction.
  int        send_gap = 0;
  huff_req_t next_req;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_tvalid && s_tready)
        pack_request({req_type_t'(s_tuser), s_tdata[7:0], s_tdata[39:8], s_tdata[45:40]});
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          s_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          next_req = pending_reqs.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= next_req.kind;
          s_tdata  <= {2'b00, next_req.len, next_req.code, next_req.sym};
          send_gap = (!calm && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Every accepted byte is matched against the oldest
  // prediction. Back-pressure comes in random stalls that can start on any
  // cycle, so they land in every step of the packer's work.
  int           stall_left = 0;
  packed_byte_t want;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_bytes.size() == 0) begin
          mismatches = mismatches + 1;
          $display("%0t: unexpected byte: expected none, actual data %h last %b",
                   $time, m_tdata, m_tlast);
        end else begin
          want = expected_bytes.pop_front();
          if (m_tdata !== want.data) begin
            mismatches = mismatches + 1;
            $display("%0t: byte mismatch: expected %h, actual %h", $time, want.data, m_tdata);
          end
          if (m_tlast !== want.last) begin
            mismatches = mismatches + 1;
            $display("%0t: last mismatch: expected %b, actual %b", $time, want.last, m_tlast);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall_left = idle_len() - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: a long spell with no request and no byte accepted means a hang.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d bytes outstanding",
               $time, expected_bytes.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Flush and unused type straight out of reset: both produce nothing.
    queue_req(REQ_FLUSH, 8'h00, 32'h0000_0000, 6'd0);
    queue_req(REQ_NONE, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    // Table corners: widest code, one-bit code at the top index, a byte-wide
    // code, a short code with junk above its length, an empty code and two
    // overlong lengths that must saturate.
    queue_req(REQ_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32);
    queue_req(REQ_LOAD, 8'hFF, 32'h0000_0001, 6'd1);
    queue_req(REQ_LOAD, 8'h01, 32'h0000_00A5, 6'd8);
    queue_req(REQ_LOAD, 8'h02, 32'hFFFF_FFF5, 6'd3);
    queue_req(REQ_LOAD, 8'h03, 32'hFFFF_FFFF, 6'd0);
    queue_req(REQ_LOAD, 8'h04, 32'h8000_0001, 6'd63);
    queue_req(REQ_LOAD, 8'h05, 32'h1234_5678, 6'd33);
    // Byte-aligned code, then build up seven pending bits so that the widest
    // code spills four bytes in one request.
    queue_req(REQ_ENCODE, 8'h01, 32'h0, 6'd0);
    queue_req(REQ_ENCODE, 8'h02, 32'h0, 6'd0);
    queue_req(REQ_ENCODE, 8'h02, 32'h0, 6'd0);
    queue_req(REQ_ENCODE, 8'hFF, 32'h0, 6'd0);
    queue_req(REQ_ENCODE, 8'h00, 32'h0, 6'd0);
    // Empty code emits nothing; then flush the partial byte, then an empty flush.
    queue_req(REQ_ENCODE, 8'h03, 32'h0, 6'd0);
    queue_req(REQ_FLUSH, 8'h00, 32'h0, 6'd0);
    queue_req(REQ_FLUSH, 8'h00, 32'h0, 6'd0);
    // Saturated lengths, with and without bits already pending.
    queue_req(REQ_ENCODE, 8'h04, 32'h0, 6'd0);
    queue_req(REQ_ENCODE, 8'hFF, 32'h0, 6'd0);
    queue_req(REQ_ENCODE, 8'h05, 32'h0, 6'd0);
    queue_req(REQ_NONE, 8'h00, 32'h0, 6'd0);
    queue_req(REQ_FLUSH, 8'h00, 32'h0, 6'd0);
    wait_drained();

    // Random traffic with idling on both sides, a burst phase with no idling
    // at all, and one more idling phase. The sender stops between phases
    // until the packer has returned everything it owes.
    queue_random(200);
    wait_drained();
    calm = 1'b1;
    queue_random(80);
    wait_drained();
    calm = 1'b0;
    queue_random(100);
    queue_req(REQ_FLUSH, 8'h00, 32'h0, 6'd0);
    wait_drained();

    // Keep watching for stray bytes for a little while.
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
